>>> hdl/wse_pkg.sv
// ----------------------------------------------------------------------------
// Windowed slope estimator package
// Shared widths, stream field layout, state encoding and control bundles.
// ----------------------------------------------------------------------------
package wse_pkg;

  // Field widths.
  localparam int CODE_W  = 16;
  localparam int SUM_W   = 19;
  localparam int SLOPE_W = 32;
  localparam int GAIN_W  = 32;
  localparam int FRAC_W  = 16;

  // Parameter defaults.
  localparam int HISTORY_DEPTH_DEF = 15;
  localparam int SAMPLES_DEF       = 8;

  // Gain register reset value, 1.0 in Q16.
  localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0001_0000;

  // Stream layout.
  localparam int IN_TDATA_W  = 2 * CODE_W;
  localparam int OUT_FIELD_W = 2 * SUM_W + 2 * SLOPE_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
  localparam int OUT_VSL_LSB = 2 * SUM_W;
  localparam int OUT_CSL_LSB = 2 * SUM_W + SLOPE_W;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_MUL,
    ST_OUT
  } state_e;

  // Controls shared by both lanes.
  typedef struct packed {
    logic add;       // accumulate the accepted code
    logic complete;  // this transaction completes a measurement
    logic fill;      // completing measurement refills the history
    logic mac;       // one weighted-sum step
    logic mul;       // apply the gain
  } lane_ctrl_t;

  // What one lane reports to the merge stage.
  typedef struct packed {
    logic signed [SUM_W-1:0]   sum;
    logic signed [SLOPE_W-1:0] slope;
    logic                      clip;
  } lane_res_t;

  // Merge stage controls.
  typedef struct packed {
    logic load;
    logic zero;
  } merge_ctrl_t;

endpackage

>>> hdl/windowed_slope_estimator.sv
// Timing: a measurement completes on every SAMPLES_PER_MEASUREMENT-th accepted
// transaction; after a refill its result passes through ST_OUT into the output register,
// otherwise through ST_MAC (one history entry per cycle in each lane), ST_MUL and ST_OUT.
// Throughput: one sample per cycle between measurements; the input stalls while the
// sequencer is busy after a measurement, and a completing sample waits for the output.
// Reset: asynchronous, active low; clears counters and flags, gain returns to 1.0 Q16.
// ----------------------------------------------------------------------------
// Windowed slope estimator
// Sums sample pairs into measurements and reports the least squares slope
// of each channel's measurement history, with the voltage and current
// channels computed in two parallel lanes.
// ----------------------------------------------------------------------------
module windowed_slope_estimator #(
  parameter int HISTORY_DEPTH           = wse_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLES_PER_MEASUREMENT = wse_pkg::SAMPLES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: slope_gain.
  input  logic                                cfg_wr_en_i,
  input  logic [wse_pkg::GAIN_W-1:0]          cfg_wr_data_i,
  // Input stream.
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [wse_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,  // voltage_code, current_code
  input  logic                                s_axis_tuser_i,  // restart
  // Output stream.
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // voltage_sum, current_sum, voltage_slope, current_slope, zero pad
  output logic [wse_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tuser_o   // slope_saturated
);
  import wse_pkg::*;

  localparam int STEP_W = $clog2(HISTORY_DEPTH);
  localparam int WGT_W  = STEP_W + 1;
  localparam int CENTER = (HISTORY_DEPTH - 1) / 2;
  localparam int CNT_W  = (SAMPLES_PER_MEASUREMENT > 1) ? $clog2(SAMPLES_PER_MEASUREMENT) : 1;
  localparam logic [CNT_W-1:0]  LAST_SAMPLE = CNT_W'(SAMPLES_PER_MEASUREMENT - 1);
  localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(HISTORY_DEPTH - 1);

  state_e             state_q;
  state_e             state_d;
  logic [GAIN_W-1:0]  gain_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [STEP_W-1:0]  step_q;
  logic               primed_q;
  logic               pend_q;
  logic               zero_q;
  logic               accept;
  logic               last;
  logic               refill;
  logic signed [WGT_W-1:0] weight;
  lane_ctrl_t         lane_ctrl;
  merge_ctrl_t        merge_ctrl;
  lane_res_t          volt_res;
  lane_res_t          curr_res;

  // Gain register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_wr_en_i) begin
      gain_q <= cfg_wr_data_i;
    end
  end

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign last   = (cnt_q == LAST_SAMPLE);
  assign refill = !primed_q || pend_q || s_axis_tuser_i;

  // Sample counter, refill flags and weighted-sum step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      primed_q <= 1'b0;
      pend_q   <= 1'b0;
      zero_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      if (accept) begin
        if (last) begin
          cnt_q    <= '0;
          primed_q <= 1'b1;
          pend_q   <= 1'b0;
          zero_q   <= refill;
        end else begin
          cnt_q  <= cnt_q + 1'b1;
          pend_q <= pend_q || s_axis_tuser_i;
        end
      end
      if (accept) begin
        step_q <= '0;
      end else if (state_q == ST_MAC) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // Centered weight of the entry now at the head of the history line.
  assign weight = $signed({1'b0, step_q}) - $signed(WGT_W'(CENTER));

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && last) begin
          state_d = refill ? ST_OUT : ST_MAC;
        end
      end
      ST_MAC: begin
        if (step_q == LAST_STEP) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready_o     = (state_q == ST_IDLE) && !(m_axis_tvalid_o && last);
    lane_ctrl.add       = accept;
    lane_ctrl.complete  = accept && last;
    lane_ctrl.fill      = refill;
    lane_ctrl.mac       = (state_q == ST_MAC);
    lane_ctrl.mul       = (state_q == ST_MUL);
    merge_ctrl.load     = (state_q == ST_OUT);
    merge_ctrl.zero     = zero_q;
  end

  // Voltage lane.
  wse_lane #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_lane_volt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .code_i   ($signed(s_axis_tdata_i[CODE_W-1:0])),
    .weight_i (weight),
    .gain_i   (gain_q),
    .res_o    (volt_res)
  );

  // Current lane.
  wse_lane #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_lane_curr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .code_i   ($signed(s_axis_tdata_i[2*CODE_W-1:CODE_W])),
    .weight_i (weight),
    .gain_i   (gain_q),
    .res_o    (curr_res)
  );

  // Merge and output register.
  wse_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (merge_ctrl),
    .volt_i          (volt_res),
    .curr_i          (curr_res),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

>>> hdl/wse_lane.sv
// ----------------------------------------------------------------------------
// Slope estimator lane
// One channel: sample accumulator, history shift line, serial weighted-sum
// unit, gain multiplier and 32-bit saturation.
// ----------------------------------------------------------------------------
module wse_lane #(
  parameter int HISTORY_DEPTH = wse_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  wse_pkg::lane_ctrl_t                      ctrl_i,
  input  logic signed [wse_pkg::CODE_W-1:0]        code_i,
  input  logic signed [$clog2(HISTORY_DEPTH):0]    weight_i,
  input  logic        [wse_pkg::GAIN_W-1:0]        gain_i,
  output wse_pkg::lane_res_t                       res_o
);
  import wse_pkg::*;

  localparam int WGT_W  = $clog2(HISTORY_DEPTH) + 1;
  localparam int TERM_W = SUM_W + WGT_W;
  localparam int ACC_W  = SUM_W + WGT_W - 1 + $clog2(HISTORY_DEPTH);
  localparam int PROD_W = ACC_W + GAIN_W + 1;
  localparam int TOP_W  = PROD_W - (FRAC_W + SLOPE_W - 1);

  logic signed [SUM_W-1:0]  acc_q;
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  hist_q [HISTORY_DEPTH];
  logic signed [TERM_W-1:0] mac_term;
  logic signed [ACC_W-1:0]  mac_q;
  logic signed [GAIN_W:0]   gain_s;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic        [TOP_W-1:0]  prod_top;
  logic                     clip;

  // Running sum of the measurement; wraps in 19 bits.
  assign sum_d = acc_q + SUM_W'(code_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.add) begin
      acc_q <= ctrl_i.complete ? '0 : sum_d;
    end
  end

  // History: index 0 is the oldest entry. The line rotates once around
  // during the weighted sum, so it ends up where it started.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.complete) begin
      sum_q <= sum_d;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        if (ctrl_i.fill || k == HISTORY_DEPTH - 1) begin
          hist_q[k] <= sum_d;
        end else begin
          hist_q[k] <= hist_q[k+1];
        end
      end
    end else if (ctrl_i.mac) begin
      for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
        hist_q[k] <= hist_q[k+1];
      end
      hist_q[HISTORY_DEPTH-1] <= hist_q[0];
    end
  end

  // Weighted sum, one entry per cycle.
  assign mac_term = hist_q[0] * weight_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.complete) begin
      mac_q <= '0;
    end else if (ctrl_i.mac) begin
      mac_q <= mac_q + ACC_W'(mac_term);
    end
  end

  // Gain multiply, registered.
  assign gain_s = $signed({1'b0, gain_i});
  assign prod_d = mac_q * gain_s;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
  end

  // Arithmetic shift by the fraction width and saturation to 32 bits.
  assign prod_top = prod_q[PROD_W-1:FRAC_W+SLOPE_W-1];
  assign clip     = !((&prod_top) || !(|prod_top));

  always_comb begin
    res_o.sum  = sum_q;
    res_o.clip = clip;
    if (!clip) begin
      res_o.slope = prod_q[FRAC_W+SLOPE_W-1:FRAC_W];
    end else if (prod_q[PROD_W-1]) begin
      res_o.slope = {1'b1, {(SLOPE_W-1){1'b0}}};
    end else begin
      res_o.slope = {1'b0, {(SLOPE_W-1){1'b1}}};
    end
  end

endmodule

>>> hdl/wse_merge.sv
// ----------------------------------------------------------------------------
// Slope estimator merge stage
// Combines both lane results into one output transaction and holds it in
// the output register until the sink takes it.
// ----------------------------------------------------------------------------
module wse_merge (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wse_pkg::merge_ctrl_t                  ctrl_i,
  input  wse_pkg::lane_res_t                    volt_i,
  input  wse_pkg::lane_res_t                    curr_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [wse_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o,
  output logic                                  m_axis_tuser_o
);
  import wse_pkg::*;

  logic                     valid_q;
  logic                     valid_d;
  logic signed [SLOPE_W-1:0] vsl;
  logic signed [SLOPE_W-1:0] csl;
  logic                     sat;
  logic [OUT_TDATA_W-1:0]   data_q;
  logic                     sat_q;

  // A refill measurement reports zero slopes and no clipping.
  assign vsl = ctrl_i.zero ? '0 : volt_i.slope;
  assign csl = ctrl_i.zero ? '0 : curr_i.slope;
  assign sat = !ctrl_i.zero && (volt_i.clip || curr_i.clip);

  // Output valid: set on load, cleared once the transaction is taken.
  assign valid_d = ctrl_i.load || (valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      data_q <= {{OUT_PAD_W{1'b0}}, csl, vsl, curr_i.sum, volt_i.sum};
      sat_q  <= sat;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = sat_q;

endmodule

>>> hdl/wse_checker.sv
// ----------------------------------------------------------------------------
// Windowed slope estimator checker
// Port-level properties of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
module wse_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid_i,
  input logic                               s_axis_tready_o,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [wse_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  input logic                               m_axis_tuser_o
);
  import wse_pkg::*;

  localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

  logic [SLOPE_W-1:0] vsl;
  logic [SLOPE_W-1:0] csl;

  assign vsl = m_axis_tdata_o[OUT_VSL_LSB +: SLOPE_W];
  assign csl = m_axis_tdata_o[OUT_CSL_LSB +: SLOPE_W];

  // A stalled result transaction stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output transaction changed while stalled");

  // The saturation flag is only raised with a slope pinned at a limit.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      (vsl == SLOPE_MAX || vsl == SLOPE_MIN || csl == SLOPE_MAX || csl == SLOPE_MIN))
    else $error("saturation flag without a clipped slope");

  // A new result never appears right after an input transaction.
  a_out_after_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("result appeared directly after an accepted sample");

endmodule

bind windowed_slope_estimator wse_checker u_wse_checker (.*);

>>> tb/windowed_slope_estimator_tb.sv
// ----------------------------------------------------------------------------
// Windowed slope estimator testbench
// Streams converter sample pairs into the estimator and checks each
// measurement (sums, slopes and clip flag) against a cycle-free predictor of
// the ring history, under random stalls on both sides and several gains.
// ----------------------------------------------------------------------------
module windowed_slope_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wse_pkg::*;

  localparam int HIST        = HISTORY_DEPTH_DEF;
  localparam int SAMPLES     = SAMPLES_DEF;
  localparam int CENTER      = (HIST - 1) / 2;
  localparam int SETTLE_CYC  = 40;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYC    = 400;
  localparam int HOLD_AT     = 30;
  localparam longint SLOPE_MAX = 64'sd2147483647;
  localparam longint SLOPE_MIN = -64'sd2147483648;

  // One completed measurement as the block reports it.
  typedef struct packed {
    logic signed [SUM_W-1:0]   vsum;
    logic signed [SUM_W-1:0]   csum;
    logic signed [SLOPE_W-1:0] vslope;
    logic signed [SLOPE_W-1:0] cslope;
    logic                      sat;
  } meas_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [GAIN_W-1:0] cfg_wr_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tuser;

  // Sample pairs waiting to be sent: {restart, current_code, voltage_code}.
  logic [IN_TDATA_W:0] pending_samples[$];
  meas_t expected_meas[$];

  int send_idle_pct = 23;
  int recv_idle_pct = 70;
  int errors = 0;
  int meas_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  // Predictor state.
  logic [GAIN_W-1:0]       gain_q = GAIN_RESET;
  logic signed [SUM_W-1:0] v_ring[HIST];
  logic signed [SUM_W-1:0] c_ring[HIST];
  int                      head = 0;
  int                      sample_cnt = 0;
  logic signed [SUM_W-1:0] v_acc = '0;
  logic signed [SUM_W-1:0] c_acc = '0;
  bit                      primed = 1'b0;
  bit                      restart_pend = 1'b0;

  windowed_slope_estimator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Weighted window sum of one channel, scaled by the gain; the top bit of
  // the return value flags saturation.
  function automatic logic [SLOPE_W:0] window_slope(input bit current_lane);
    longint acc;
    longint prod;
    longint q;
    int idx;
    bit clip;
    acc = 0;
    clip = 1'b0;
    for (int j = 0; j < HIST; j++) begin
      idx = (head + 1 + j) % HIST;
      acc += (current_lane ? longint'(c_ring[idx]) : longint'(v_ring[idx])) * (j - CENTER);
    end
    prod = acc * $signed({32'd0, gain_q});
    q = prod >>> FRAC_W;
    if (q > SLOPE_MAX) begin
      q = SLOPE_MAX;
      clip = 1'b1;
    end else if (q < SLOPE_MIN) begin
      q = SLOPE_MIN;
      clip = 1'b1;
    end
    return {clip, q[SLOPE_W-1:0]};
  endfunction

  // Advance the predictor by one accepted sample pair.
  task automatic predict_sample(input logic signed [CODE_W-1:0] vcode,
                                input logic signed [CODE_W-1:0] ccode,
                                input logic restart);
    meas_t m;
    logic [SLOPE_W:0] vr;
    logic [SLOPE_W:0] cr;
    v_acc = v_acc + vcode;
    c_acc = c_acc + ccode;
    if (restart) restart_pend = 1'b1;
    sample_cnt++;
    if (sample_cnt < SAMPLES) return;
    m.vsum = v_acc;
    m.csum = c_acc;
    sample_cnt = 0;
    v_acc = '0;
    c_acc = '0;
    if (!primed || restart_pend) begin
      // A fresh history: every entry takes this measurement.
      for (int j = 0; j < HIST; j++) begin
        v_ring[j] = m.vsum;
        c_ring[j] = m.csum;
      end
      head = 0;
      primed = 1'b1;
      restart_pend = 1'b0;
      m.vslope = '0;
      m.cslope = '0;
      m.sat = 1'b0;
    end else begin
      head = (head + 1) % HIST;
      v_ring[head] = m.vsum;
      c_ring[head] = m.csum;
      vr = window_slope(1'b0);
      cr = window_slope(1'b1);
      m.vslope = vr[SLOPE_W-1:0];
      m.cslope = cr[SLOPE_W-1:0];
      m.sat = vr[SLOPE_W] | cr[SLOPE_W];
    end
    expected_meas.push_back(m);
  endtask

  function automatic void compare_field(input string name, input longint exp_v,
                                        input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Check one measurement transaction against the oldest expectation.
  task automatic check_meas(input logic [OUT_TDATA_W-1:0] data, input logic sat);
    meas_t e;
    if (expected_meas.size() == 0) begin
      $display("%0t: unexpected measurement, expected none, got tdata %h", $time, data);
      errors++;
      return;
    end
    e = expected_meas.pop_front();
    compare_field("voltage_sum", e.vsum, $signed(data[SUM_W-1:0]));
    compare_field("current_sum", e.csum, $signed(data[2*SUM_W-1:SUM_W]));
    compare_field("voltage_slope", e.vslope, $signed(data[OUT_VSL_LSB +: SLOPE_W]));
    compare_field("current_slope", e.cslope, $signed(data[OUT_CSL_LSB +: SLOPE_W]));
    compare_field("slope_saturated", e.sat, sat);
    meas_seen++;
  endtask

  // Sample driver: a held pair stays put until it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) predict_sample(s_tdata[CODE_W-1:0], s_tdata[IN_TDATA_W-1:CODE_W], s_tuser);
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        {s_tuser, s_tdata} <= pending_samples.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Measurement monitor with random back pressure and one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_meas(m_tdata, m_tuser);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (!hold_done && meas_seen == HOLD_AT) begin
        hold_left <= HOLD_CYC;
        hold_done <= 1'b1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [CODE_W-1:0] rand_code();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return CODE_W'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++)
      pending_samples.push_back({($urandom_range(199) == 0), rand_code(), rand_code()});
  endtask

  // Wait until every sample is sent and every measurement has arrived.
  task automatic drain();
    while (pending_samples.size() > 0 || s_tvalid || expected_meas.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    @(posedge clk_i);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= g;
    @(posedge clk_i);
    cfg_wr_en <= 1'b0;
    gain_q = g;
  endtask

  initial begin
    for (int j = 0; j < HIST; j++) begin
      v_ring[j] = '0;
      c_ring[j] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme sums on first fill, restart in mid measurement,
    // restart on the completing sample, all at the reset gain.
    for (int i = 0; i < SAMPLES; i++)
      pending_samples.push_back({1'b0, 16'h8000, 16'h7FFF});
    for (int i = 0; i < SAMPLES; i++)
      pending_samples.push_back({(i == 3), 16'h7FFF, 16'h8000});
    for (int i = 0; i < SAMPLES; i++)
      pending_samples.push_back({(i == SAMPLES - 1), 16'(-i), 16'(i + 1)});
    drain();

    // Full-scale gain saturates most slopes; the long hold-off falls here.
    write_gain(32'hFFFF_FFFF);
    queue_random(450);
    drain();

    send_idle_pct = 70;
    recv_idle_pct = 23;
    write_gain(32'h0000_0000);
    queue_random(300);
    drain();

    write_gain($urandom_range(32'h0004_0000));
    queue_random(400);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_gain(32'h0000_0001);
    queue_random(300);
    drain();

    write_gain($urandom);
    queue_random(300);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
